// ===== rtl/fhct_pkg.sv =====
// Shared types and constants for the FIFO-replaced hit counter table.
// No dependencies; used by the controller, the datapath and the top level.
package fhct_pkg;

  localparam int KEY_W      = 32;
  localparam int COUNT_W    = 7;
  localparam int IN_DATA_W  = 3 * KEY_W;
  localparam int OUT_DATA_W = 16;

  localparam logic [COUNT_W-1:0] COUNT_MAX   = 7'd127;
  localparam logic [COUNT_W-1:0] LIMIT_RESET = 7'd5;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MATCH,
    ST_UPDATE
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic latch;   // capture the incoming key
    logic match;   // register the per-entry compare result
    logic commit;  // update the table and load the output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_busy;  // output register holds a result not taken this cycle
  } status_t;

endpackage

// ===== rtl/fhct_ctrl.sv =====
// Sequencing controller: latch key, compare, commit one item at a time.
// Depends on fhct_pkg for the state and command/status types.
module fhct_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  fhct_pkg::status_t sts,
  output fhct_pkg::cmd_t    cmd
);

  fhct_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fhct_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    in_tready  = 1'b0;
    cmd        = '0;
    case (state_r)
      fhct_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.latch = 1'b1;
          state_nxt = fhct_pkg::ST_MATCH;
        end
      end
      fhct_pkg::ST_MATCH: begin
        cmd.match = 1'b1;
        state_nxt = fhct_pkg::ST_UPDATE;
      end
      fhct_pkg::ST_UPDATE: begin
        // hold until the output register can take the result
        if (!sts.out_busy) begin
          cmd.commit = 1'b1;
          state_nxt  = fhct_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = fhct_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/fhct_datapath.sv =====
// Table storage, parallel key compare, count update and output register.
// Depends on fhct_pkg for widths, constants and the command/status types.
module fhct_datapath #(
  parameter int TABLE_ENTRIES = 10
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [fhct_pkg::IN_DATA_W-1:0]      in_tdata,
  input  logic                                cfg_wr_en,
  input  logic [fhct_pkg::COUNT_W-1:0]        cfg_wr_data,
  input  fhct_pkg::cmd_t                      cmd,
  output fhct_pkg::status_t                   sts,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [fhct_pkg::OUT_DATA_W-1:0]     out_tdata
);

  localparam int SLOT_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int KW     = fhct_pkg::KEY_W;
  localparam int CW     = fhct_pkg::COUNT_W;

  logic [CW-1:0]           limit_r;
  logic [fhct_pkg::IN_DATA_W-1:0] key_r;

  logic [KW-1:0]           ent_x_r [TABLE_ENTRIES];
  logic [KW-1:0]           ent_y_r [TABLE_ENTRIES];
  logic [KW-1:0]           ent_z_r [TABLE_ENTRIES];
  logic [CW-1:0]           ent_cnt_r [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] valid_r;
  logic [SLOT_W-1:0]       oldest_r, oldest_nxt;
  logic [TABLE_ENTRIES-1:0] match_r, match_nxt;

  logic [TABLE_ENTRIES-1:0] oldest_oh, hit_first, sel;
  logic                    present, limit_zero, do_update;
  logic [CW-1:0]           old_cnt, new_cnt;

  logic                    out_valid_r;
  logic                    allowed_r, present_r;
  logic [CW-1:0]           count_r;

  assign limit_zero = (limit_r == '0);
  assign do_update  = cmd.commit && !limit_zero;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= fhct_pkg::LIMIT_RESET;
    end else if (cfg_wr_en) begin
      limit_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      key_r <= in_tdata;
    end
  end

  // per-entry compare
  always_comb begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      match_nxt[i] = valid_r[i] &&
                     (ent_x_r[i] == key_r[KW-1:0]) &&
                     (ent_y_r[i] == key_r[2*KW-1:KW]) &&
                     (ent_z_r[i] == key_r[3*KW-1:2*KW]);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.match) begin
      match_r <= match_nxt;
    end
  end

  // slot selection and count update
  always_comb begin
    present   = |match_r;
    hit_first = match_r & (~match_r + 1'b1);
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      oldest_oh[i] = (oldest_r == SLOT_W'(i));
    end
    sel     = present ? hit_first : oldest_oh;
    old_cnt = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      old_cnt = old_cnt | ({CW{sel[i] & present}} & ent_cnt_r[i]);
    end
    new_cnt = (old_cnt == fhct_pkg::COUNT_MAX) ? old_cnt : old_cnt + 1'b1;
    if (oldest_r == SLOT_W'(TABLE_ENTRIES - 1)) begin
      oldest_nxt = '0;
    end else begin
      oldest_nxt = oldest_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (do_update && sel[i]) begin
        ent_cnt_r[i] <= new_cnt;
        if (!present) begin
          ent_x_r[i] <= key_r[KW-1:0];
          ent_y_r[i] <= key_r[2*KW-1:KW];
          ent_z_r[i] <= key_r[3*KW-1:2*KW];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      oldest_r <= '0;
    end else if (do_update && !present) begin
      valid_r  <= valid_r | sel;
      oldest_r <= oldest_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (limit_zero) begin
        allowed_r <= 1'b1;
        present_r <= 1'b0;
        count_r   <= '0;
      end else begin
        allowed_r <= (new_cnt <= limit_r);
        present_r <= present;
        count_r   <= new_cnt;
      end
    end
  end

  assign sts.out_busy = out_valid_r && !out_tready;
  assign out_tvalid   = out_valid_r;
  assign out_tdata    = {{(fhct_pkg::OUT_DATA_W - CW - 2){1'b0}}, count_r, present_r, allowed_r};

endmodule

// ===== rtl/fifo_replaced_hit_counter_table_top.sv =====
// Top level of the FIFO-replaced hit counter table.
// Depends on fhct_pkg, fhct_ctrl and fhct_datapath.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+--------------------------------------
//  in_     | sink      | in_tvalid/in_tready  | in_tdata: key_x, key_y, key_z
//  out_    | source    | out_tvalid/out_tready| out_tdata: allowed, was_present, use_count
//  cfg_    | sink      | cfg_wr_en            | cfg_wr_data: use_limit
//
// Each item runs through three steps: accept and latch the key, compare it against
// every entry in parallel, then commit the table update and the result.
// The commit waits only while the output register holds an untaken result;
// the next key is accepted while a finished result waits downstream.
// Reset (synchronous, active low) clears valid bits, replacement pointer and
// the output valid, and sets use_limit to 5. Key and count storage is not reset.
module fifo_replaced_hit_counter_table_top #(
  parameter int TABLE_ENTRIES = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  // key_x [31:0], key_y [63:32], key_z [95:64]
  input  logic [95:0] in_tdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  // allowed [0], was_present [1], use_count [8:2], zero [15:9]
  output logic [15:0] out_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  logic        cfg_wr_en,
  input  logic [6:0]  cfg_wr_data
);

  fhct_pkg::cmd_t    cmd;
  fhct_pkg::status_t sts;

  // sequence one item at a time
  fhct_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // table, compare, update and output register
  fhct_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .sts         (sts),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

  // one item in flight: after a transfer in, no new key until the commit
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while an item is still in work");

  // a zero count only comes from the disabled path
  a_zero_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[8:2] == 7'd0) |-> out_tdata[0] && !out_tdata[1])
    else $error("zero count with counting enabled");

  // a hit always carries a count of at least two
  a_hit_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1] |-> (out_tdata[8:2] != 7'd0) && (out_tdata[8:2] != 7'd1))
    else $error("hit with a count below two");

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for fifo_replaced_hit_counter_table_top.
// Depends on fhct_pkg and the RTL top level; it keeps its own model of the table.
module testbench;

  localparam int TABLE_ENTRIES = 10;
  localparam int KEY_W         = fhct_pkg::KEY_W;
  localparam int COUNT_W       = fhct_pkg::COUNT_W;
  localparam int IN_DATA_W     = fhct_pkg::IN_DATA_W;
  localparam int OUT_DATA_W    = fhct_pkg::OUT_DATA_W;
  localparam int IDLE_PCT      = 23;
  localparam int STALL_LIMIT   = 4000;  // cycles with no transfer before giving up
  localparam int TAIL_CYCLES   = 20;

  // Fields of one result as the block should report it
  typedef struct {
    logic               allowed;
    logic               was_present;
    logic [COUNT_W-1:0] use_count;
  } verdict_t;

  logic                  clk;
  logic                  rst_n;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic                  cfg_wr_en;
  logic [COUNT_W-1:0]    cfg_wr_data;

  // Shadow copy of the table, the replacement pointer and the limit
  logic [KEY_W-1:0]   tbl_kx [TABLE_ENTRIES];
  logic [KEY_W-1:0]   tbl_ky [TABLE_ENTRIES];
  logic [KEY_W-1:0]   tbl_kz [TABLE_ENTRIES];
  logic [COUNT_W-1:0] tbl_cnt [TABLE_ENTRIES];
  logic               tbl_valid [TABLE_ENTRIES];
  int                 fifo_head;
  logic [COUNT_W-1:0] limit_shadow;

  verdict_t verdict_q[$];  // predicted results not yet seen on the output
  int       errors;
  int       quiet_cycles;
  logic     tx_idle_en;    // sender inserts random gaps
  logic     rx_stall_en;   // receiver drops tready at random

  fifo_replaced_hit_counter_table_top #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #4 clk = ~clk;

  // Compute the result of one lookup and advance the shadow table.
  // A zero limit bypasses the table entirely; a hit leaves the FIFO order alone.
  function automatic verdict_t predict_use(input logic [KEY_W-1:0] kx,
                                           input logic [KEY_W-1:0] ky,
                                           input logic [KEY_W-1:0] kz);
    verdict_t           v;
    int                 slot;
    logic               hit;
    logic [COUNT_W-1:0] cnt;
    v.allowed     = 1'b1;
    v.was_present = 1'b0;
    v.use_count   = '0;
    if (limit_shadow == '0) return v;
    slot = -1;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (slot < 0 && tbl_valid[i] && tbl_kx[i] == kx && tbl_ky[i] == ky && tbl_kz[i] == kz)
        slot = i;
    end
    hit = (slot >= 0);
    if (!hit) begin
      // Miss: overwrite the entry inserted earliest
      slot            = fifo_head;
      tbl_kx[slot]    = kx;
      tbl_ky[slot]    = ky;
      tbl_kz[slot]    = kz;
      tbl_cnt[slot]   = '0;
      tbl_valid[slot] = 1'b1;
      fifo_head       = (fifo_head + 1) % TABLE_ENTRIES;
    end
    cnt = tbl_cnt[slot];
    if (cnt != fhct_pkg::COUNT_MAX) cnt = cnt + 1'b1;  // saturate instead of wrapping
    tbl_cnt[slot]  = cnt;
    v.allowed      = (cnt <= limit_shadow);
    v.was_present  = hit;
    v.use_count    = cnt;
    return v;
  endfunction

  // Drive one key and hold it until the block takes it. Entered and left at a
  // falling edge; every step assigns in_tvalid at most once.
  task automatic send_key(input logic [KEY_W-1:0] kx, input logic [KEY_W-1:0] ky,
                          input logic [KEY_W-1:0] kz);
    while (tx_idle_en && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {kz, ky, kx};
    do @(posedge clk); while (!in_tready);
    // Transfer done at this edge: record what the block must answer
    verdict_q.push_back(predict_use(kx, ky, kz));
    @(negedge clk);
  endtask

  // Drop valid and hold off until every predicted result has come back.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (verdict_q.size() != 0) @(negedge clk);
  endtask

  // Write use_limit while the block is idle.
  task automatic set_limit(input logic [COUNT_W-1:0] value);
    drain_results();
    cfg_wr_en    <= 1'b1;
    cfg_wr_data  <= value;
    limit_shadow = value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  // Key words biased toward the edges of the range
  function automatic logic [KEY_W-1:0] pick_word();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      2:       return KEY_W'(1) << $urandom_range(KEY_W - 1);
      default: return $urandom;
    endcase
  endfunction

  // Reset value of the limit: count two keys past the limit of five
  task automatic test_limit_edges();
    for (int i = 0; i < 7; i++) send_key('0, '0, '0);
  endtask

  // Raw bit compare: keys that differ in a single word are distinct entries
  task automatic test_key_words();
    send_key('1, '1, '1);
    send_key('0, '0, 32'h8000_0000);
    send_key('0, 32'h0000_0001, '0);
    send_key('1, '0, '0);
  endtask

  // Limit zero allows everything and leaves the table untouched
  task automatic test_limit_zero();
    set_limit('0);
    send_key('0, '0, '0);
    send_key(32'h1234_5678, 32'h9abc_def0, 32'h0f0f_0f0f);
    set_limit(7'd3);
    send_key('0, '0, '0);  // still present, count carries on
  endtask

  // Fill the table with fresh keys, hit the oldest, then force one eviction
  task automatic test_fifo_eviction();
    logic [KEY_W-1:0] base;
    base = 32'hc0de_0000;
    for (int i = 0; i < TABLE_ENTRIES; i++) send_key(base + i, ~(base + i), base);
    send_key(base, ~base, base);                 // hit; must not refresh
    send_key(32'hdead_beef, 32'hfeed_face, '1);  // evicts the first fresh key
    send_key(base, ~base, base);                 // miss now
  endtask

  // One phase of random traffic: mostly keys from a small pool, so that hits,
  // evictions and re-insertions happen, plus a share of fully random keys.
  task automatic run_mix_phase(input logic [COUNT_W-1:0] limit, input int n_items,
                               input int pool_size, input int noise_pct,
                               input bit pause_midway);
    logic [IN_DATA_W-1:0] pool [32];
    logic [IN_DATA_W-1:0] k;
    int                   w;
    set_limit(limit);
    for (int i = 0; i < pool_size; i++) begin
      if (i > 0 && $urandom_range(3) == 0) begin
        // near neighbor: same key with one word changed
        k = pool[$urandom_range(i - 1)];
        w = $urandom_range(2);
        k[w*KEY_W +: KEY_W] = pick_word();
        pool[i] = k;
      end else begin
        pool[i] = {pick_word(), pick_word(), pick_word()};
      end
    end
    for (int n = 0; n < n_items; n++) begin
      if (pause_midway && n == n_items / 2) drain_results();
      if ($urandom_range(99) < noise_pct) k = {$urandom, $urandom, $urandom};
      else k = pool[$urandom_range(pool_size - 1)];
      send_key(k[KEY_W-1:0], k[2*KEY_W-1:KEY_W], k[3*KEY_W-1:2*KEY_W]);
    end
  endtask

  task automatic test_random_mix();
    run_mix_phase(7'd1, 200, 12, 15, 1'b0);
    // no idling on either side for this stretch
    tx_idle_en  = 1'b0;
    rx_stall_en = 1'b0;
    run_mix_phase(7'd2, 200, 8, 10, 1'b0);
    tx_idle_en  = 1'b1;
    rx_stall_en = 1'b1;
    run_mix_phase(7'd100, 200, 14, 15, 1'b1);
    run_mix_phase('0, 150, 8, 20, 1'b0);
    run_mix_phase(COUNT_W'($urandom_range(127, 101)), 200, 11, 15, 1'b0);
    run_mix_phase(COUNT_W'($urandom_range(127, 1)), 200, 20, 30, 1'b0);
    run_mix_phase(fhct_pkg::LIMIT_RESET, 200, 10, 15, 1'b0);
  endtask

  // Drive counts into saturation: refused at 127 under a limit of 126, allowed under 127
  task automatic test_saturation();
    run_mix_phase(7'd126, 280, 2, 0, 1'b0);
    run_mix_phase(fhct_pkg::COUNT_MAX, 150, 1, 0, 1'b0);
  endtask

  // Compare every result transfer with the oldest prediction
  always @(posedge clk) begin
    verdict_t exp_v;
    if (rst_n && out_tvalid && out_tready) begin
      if (verdict_q.size() == 0) begin
        $error("unexpected result out_tdata=%h", out_tdata);
        errors++;
      end else begin
        exp_v = verdict_q.pop_front();
        if (out_tdata[0] !== exp_v.allowed) begin
          $error("allowed: expected %0d, actual %0d", exp_v.allowed, out_tdata[0]);
          errors++;
        end
        if (out_tdata[1] !== exp_v.was_present) begin
          $error("was_present: expected %0d, actual %0d", exp_v.was_present, out_tdata[1]);
          errors++;
        end
        if (out_tdata[8:2] !== exp_v.use_count) begin
          $error("use_count: expected %0d, actual %0d", exp_v.use_count, out_tdata[8:2]);
          errors++;
        end
        if (out_tdata[15:9] !== '0) begin
          $error("zero: expected 0, actual %0h", out_tdata[15:9]);
          errors++;
        end
      end
    end
  end

  // Watchdog: count cycles in which neither channel moves a transfer
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("testbench: FAIL");
        $finish;
      end
    end
  end

  // Receiver: randomly withhold tready, changed only at the falling edge
  always @(negedge clk) begin
    out_tready <= !rx_stall_en || ($urandom_range(99) >= IDLE_PCT);
  end

  initial begin
    clk          = 1'b0;
    rst_n        = 1'b0;
    in_tdata     = '0;
    in_tvalid    = 1'b0;
    out_tready   = 1'b0;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = '0;
    errors       = 0;
    quiet_cycles = 0;
    tx_idle_en   = 1'b1;
    rx_stall_en  = 1'b1;
    fifo_head    = 0;
    limit_shadow = fhct_pkg::LIMIT_RESET;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_cnt[i]   = '0;
      tbl_kx[i]    = '0;
      tbl_ky[i]    = '0;
      tbl_kz[i]    = '0;
    end
    // Hold reset, then release it at a falling edge
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_limit_edges();
    test_key_words();
    test_limit_zero();
    test_fifo_eviction();
    test_random_mix();
    test_saturation();

    // Wait for the last results, then let the pipeline settle
    drain_results();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (verdict_q.size() != 0) begin
      $error("%0d predicted results never arrived", verdict_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/fhct_pkg.sv
rtl/fhct_ctrl.sv
rtl/fhct_datapath.sv
rtl/fifo_replaced_hit_counter_table_top.sv
verif/testbench.sv
